[design/lsra_pkg.sv]
// ============================================================================
// Linear scan register allocator package
// Shared constants, types and codes for the allocator controller and datapath.
// ============================================================================
package lsra_pkg;

    localparam int POOL_REGS  = 9;
    localparam int IDX_W      = $clog2(POOL_REGS + 1);
    localparam int POS_W      = (POOL_REGS > 1) ? $clog2(POOL_REGS) : 1;
    localparam int REG_W      = 4;
    localparam int PNT_W      = 16;
    localparam int ID_W       = 16;
    localparam int OFF_W      = 18;
    localparam int SLOT_BYTES = 4;
    localparam logic [OFF_W-1:0] OFFSET_MAX = 18'd262140;

    typedef enum logic [1:0] {
        OUT_FREE  = 2'd0,
        OUT_STEAL = 2'd1,
        OUT_SPILL = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MARK,
        ST_RETURN,
        ST_COMPACT,
        ST_DECIDE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic init;
        logic cfg;
        logic load;
        logic mark;
        logic ret;
        logic compact;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic ret_done;
        logic compact_done;
    } t_status;

endpackage

[design/lsra_ctrl.sv]
// ============================================================================
// Linear scan register allocator controller
// Sequences expiry marking, ordered register return, compaction and decision.
// ============================================================================
module lsra_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_in_acc,
    input  logic               i_out_acc,
    input  lsra_pkg::t_status  i_status,
    output lsra_pkg::t_cmd     o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output logic               o_cfg_ready
);

    lsra_pkg::t_state r_state;
    lsra_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsra_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsra_pkg::ST_INIT: n_state = lsra_pkg::ST_IDLE;
            lsra_pkg::ST_IDLE: begin
                if (i_cfg_we) begin
                    n_state = lsra_pkg::ST_INIT;
                end else if (i_in_acc) begin
                    n_state = lsra_pkg::ST_MARK;
                end
            end
            lsra_pkg::ST_MARK: n_state = lsra_pkg::ST_RETURN;
            lsra_pkg::ST_RETURN: begin
                if (i_status.ret_done) begin
                    n_state = lsra_pkg::ST_COMPACT;
                end
            end
            lsra_pkg::ST_COMPACT: begin
                if (i_status.compact_done) begin
                    n_state = lsra_pkg::ST_DECIDE;
                end
            end
            lsra_pkg::ST_DECIDE: n_state = lsra_pkg::ST_OUT;
            lsra_pkg::ST_OUT: begin
                if (i_out_acc) begin
                    n_state = lsra_pkg::ST_IDLE;
                end
            end
            default: n_state = lsra_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cfg_ready   = 1'b0;
        unique case (r_state)
            lsra_pkg::ST_INIT: o_cmd.init = 1'b1;
            lsra_pkg::ST_IDLE: begin
                o_in_ready  = ~i_cfg_we;
                o_cfg_ready = 1'b1;
                o_cmd.cfg   = i_cfg_we;
                o_cmd.load  = i_in_acc & ~i_cfg_we;
            end
            lsra_pkg::ST_MARK:    o_cmd.mark    = 1'b1;
            lsra_pkg::ST_RETURN:  o_cmd.ret     = 1'b1;
            lsra_pkg::ST_COMPACT: o_cmd.compact = 1'b1;
            lsra_pkg::ST_DECIDE:  o_cmd.decide  = 1'b1;
            lsra_pkg::ST_OUT:     o_out_valid   = 1'b1;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_acc |=> o_out_valid)
        else $error("result dropped while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while result pending");
    a_decide_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decide |=> o_out_valid)
        else $error("decision not presented");
`endif

endmodule

[design/lsra_dp.sv]
// ============================================================================
// Linear scan register allocator datapath
// Active set, free register FIFO, stack slot counter and result register.
// ============================================================================
module lsra_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsra_pkg::t_cmd                i_cmd,
    input  logic [3:0]                    i_cfg_count,
    input  logic [lsra_pkg::PNT_W-1:0]    i_start_point,
    input  logic [lsra_pkg::PNT_W-1:0]    i_end_point,
    input  logic [lsra_pkg::ID_W-1:0]     i_value_id,
    output lsra_pkg::t_status             o_status,
    output logic [1:0]                    o_outcome,
    output logic [lsra_pkg::REG_W-1:0]    o_reg_index,
    output logic [lsra_pkg::ID_W-1:0]     o_spilled_id,
    output logic [lsra_pkg::OFF_W-1:0]    o_spill_offset,
    output logic [3:0]                    o_expired_count
);

    localparam int N  = lsra_pkg::POOL_REGS;
    localparam int IW = lsra_pkg::IDX_W;
    localparam int PW = lsra_pkg::POS_W;

    logic [N-1:0]                 r_valid;
    logic [lsra_pkg::PNT_W-1:0]   r_end [N];
    logic [lsra_pkg::ID_W-1:0]    r_id  [N];
    logic [lsra_pkg::REG_W-1:0]   r_reg [N];
    logic [lsra_pkg::REG_W-1:0]   r_fifo [N];
    logic [PW-1:0]                r_head;
    logic [IW-1:0]                r_fcnt;
    logic [IW-1:0]                r_limit;
    logic [lsra_pkg::OFF_W-1:0]   r_slot;
    logic [N-1:0]                 r_exp;
    logic [lsra_pkg::PNT_W-1:0]   r_start;
    logic [lsra_pkg::PNT_W-1:0]   r_new_end;
    logic [lsra_pkg::ID_W-1:0]    r_new_id;
    logic [3:0]                   r_nexp;
    logic [PW-1:0]                r_cpos;
    logic [1:0]                   r_outcome;
    logic [lsra_pkg::REG_W-1:0]   r_out_reg;
    logic [lsra_pkg::ID_W-1:0]    r_out_sid;
    logic [lsra_pkg::OFF_W-1:0]   r_out_off;

    logic [IW-1:0]                n_limit;
    logic                         best_found;
    logic [PW-1:0]                best_pos;
    logic [PW-1:0]                last_pos;
    logic                         last_found;
    logic [IW-1:0]                act_cnt;
    logic [PW-1:0]                top_pos;
    logic [PW-1:0]                tail;
    logic [IW:0]                  tail_sum;
    logic [PW-1:0]                head_nx;
    logic [lsra_pkg::OFF_W-1:0]   slot_nx;

    assign n_limit = (i_cfg_count > 4'(N)) ? IW'(N) : IW'(i_cfg_count);

    always_comb begin
        best_found = 1'b0;
        best_pos   = '0;
        for (int i = 0; i < N; i++) begin
            if (r_exp[i] && (!best_found || r_id[i] < r_id[best_pos])) begin
                best_found = 1'b1;
                best_pos   = PW'(i);
            end
        end
    end

    always_comb begin
        last_found = 1'b0;
        last_pos   = '0;
        act_cnt    = '0;
        for (int i = 0; i < N; i++) begin
            if (r_valid[i]) begin
                act_cnt = act_cnt + 1'b1;
                if (!last_found || r_end[i] >= r_end[last_pos]) begin
                    last_found = 1'b1;
                    last_pos   = PW'(i);
                end
            end
        end
    end

    assign top_pos  = act_cnt[PW-1:0] - 1'b1;
    assign tail_sum = (IW+1)'(r_head) + (IW+1)'(r_fcnt);
    assign tail     = (tail_sum >= (IW+1)'(N)) ? PW'(tail_sum - (IW+1)'(N)) : PW'(tail_sum);
    assign head_nx  = (r_head == PW'(N - 1)) ? '0 : r_head + 1'b1;
    assign slot_nx  = (r_slot <= lsra_pkg::OFFSET_MAX - lsra_pkg::OFF_W'(lsra_pkg::SLOT_BYTES))
                      ? r_slot + lsra_pkg::OFF_W'(lsra_pkg::SLOT_BYTES) : lsra_pkg::OFFSET_MAX;

    assign o_status.ret_done     = (r_exp == '0);
    assign o_status.compact_done = (r_cpos == PW'(N - 1)) || (N == 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= '0;
            r_fcnt  <= IW'(N);
            r_limit <= IW'(N);
            r_slot  <= '0;
            r_exp   <= '0;
            r_cpos  <= '0;
        end else begin
            if (i_cmd.init) begin
                r_valid <= '0;
                r_head  <= '0;
                r_fcnt  <= r_limit;
                r_slot  <= '0;
                for (int i = 0; i < N; i++) begin
                    r_fifo[i] <= lsra_pkg::REG_W'(i);
                end
            end
            if (i_cmd.load) begin
                r_start   <= i_start_point;
                r_new_end <= i_end_point;
                r_new_id  <= i_value_id;
            end
            if (i_cmd.mark) begin
                r_nexp <= '0;
                r_cpos <= '0;
                for (int i = 0; i < N; i++) begin
                    r_exp[i] <= r_valid[i] && (r_end[i] < r_start);
                end
            end
            if (i_cmd.ret && best_found) begin
                r_exp[best_pos] <= 1'b0;
                r_valid[best_pos] <= 1'b0;
                r_nexp <= r_nexp + 1'b1;
                if (r_fcnt < IW'(N)) begin
                    r_fifo[tail] <= r_reg[best_pos];
                    r_fcnt <= r_fcnt + 1'b1;
                end
            end
            if (i_cmd.compact) begin
                if (!r_valid[r_cpos] && (N > 1)) begin
                    for (int i = 0; i < N - 1; i++) begin
                        if (PW'(i) >= r_cpos) begin
                            r_valid[i] <= r_valid[i+1];
                            r_end[i]   <= r_end[i+1];
                            r_id[i]    <= r_id[i+1];
                            r_reg[i]   <= r_reg[i+1];
                        end
                    end
                    r_valid[N-1] <= 1'b0;
                    if (r_valid[N-1:0] >> r_cpos == '0) begin
                        r_cpos <= PW'(N - 1);
                    end
                end else if (r_cpos != PW'(N - 1)) begin
                    r_cpos <= r_cpos + 1'b1;
                end
            end
            if (i_cmd.decide) begin
                if (act_cnt < r_limit && r_fcnt != '0) begin
                    r_head <= head_nx;
                    r_fcnt <= r_fcnt - 1'b1;
                    r_valid[act_cnt[PW-1:0]] <= 1'b1;
                    r_end[act_cnt[PW-1:0]]   <= r_new_end;
                    r_id[act_cnt[PW-1:0]]    <= r_new_id;
                    r_reg[act_cnt[PW-1:0]]   <= r_fifo[r_head];
                    r_outcome <= lsra_pkg::OUT_FREE;
                    r_out_reg <= r_fifo[r_head];
                    r_out_sid <= '0;
                    r_out_off <= '0;
                end else if (last_found && r_end[last_pos] > r_new_end) begin
                    r_slot <= slot_nx;
                    for (int i = 0; i < N - 1; i++) begin
                        if (PW'(i) >= last_pos && PW'(i) != top_pos) begin
                            r_end[i] <= r_end[i+1];
                            r_id[i]  <= r_id[i+1];
                            r_reg[i] <= r_reg[i+1];
                        end
                    end
                    r_end[top_pos] <= r_new_end;
                    r_id[top_pos]  <= r_new_id;
                    r_reg[top_pos] <= r_reg[last_pos];
                    r_outcome <= lsra_pkg::OUT_STEAL;
                    r_out_reg <= r_reg[last_pos];
                    r_out_sid <= r_id[last_pos];
                    r_out_off <= r_slot;
                end else begin
                    r_slot    <= slot_nx;
                    r_outcome <= lsra_pkg::OUT_SPILL;
                    r_out_reg <= '0;
                    r_out_sid <= r_new_id;
                    r_out_off <= r_slot;
                end
            end
            if (i_cmd.cfg) begin
                r_limit <= n_limit;
            end
        end
    end

    assign o_outcome       = r_outcome;
    assign o_reg_index     = r_out_reg;
    assign o_spilled_id    = r_out_sid;
    assign o_spill_offset  = r_out_off;
    assign o_expired_count = r_nexp;

`ifndef SYNTHESIS
    a_fcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= IW'(N))
        else $error("free count overflow");
    a_slot_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.decide) && !$past(i_cmd.init) && r_outcome != lsra_pkg::OUT_FREE
        |-> r_slot == $past(slot_nx))
        else $error("stack slot not advanced");
    a_ret_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |-> r_exp == '0)
        else $error("expiry incomplete at decision");
`endif

endmodule

[design/linear_scan_register_allocator_core.sv]
// ============================================================================
// Linear scan register allocator core
// Allocates a register or a spill slot to each live interval.
// ============================================================================
// An interval is accepted only while the allocator is idle. After acceptance,
// the mark state marks the active intervals that expire, the return state gives
// back the expired registers in ascending value id order, the compaction state
// closes the gaps in the active set, and the decide state makes the decision.
// The result beat is held until taken, and the next interval is accepted in
// the cycle after that. A configuration write is taken only while idle and
// re-initializes the allocator.
module linear_scan_register_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_start_point,
    input  logic [15:0] i_end_point,
    input  logic [15:0] i_value_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_outcome,
    output logic [3:0]  o_reg_index,
    output logic [15:0] o_spilled_id,
    output logic [17:0] o_spill_offset,
    output logic [3:0]  o_expired_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    lsra_pkg::t_cmd    cmd;
    lsra_pkg::t_status status;
    logic              in_ready;
    logic              cfg_we;
    logic              in_acc;
    logic              out_acc;

    assign o_stall = ~in_ready;
    assign in_acc  = i_valid & in_ready;
    assign out_acc = o_valid & ~i_stall;
    assign cfg_we  = i_cfg_valid & o_cfg_ready;

    lsra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_in_acc    (in_acc),
        .i_out_acc   (out_acc),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (o_valid),
        .o_cfg_ready (o_cfg_ready)
    );

    lsra_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_count     (i_cfg_data),
        .i_start_point   (i_start_point),
        .i_end_point     (i_end_point),
        .i_value_id      (i_value_id),
        .o_status        (status),
        .o_outcome       (o_outcome),
        .o_reg_index     (o_reg_index),
        .o_spilled_id    (o_spilled_id),
        .o_spill_offset  (o_spill_offset),
        .o_expired_count (o_expired_count)
    );

endmodule

[sim/testbench.sv]
// ============================================================================
// Linear scan register allocator testbench
// Drives live intervals through the allocator core with random idling on both
// sides, predicts each allocation decision and compares every result beat.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic [15:0] start_point;
        logic [15:0] end_point;
        logic [15:0] value_id;
    } t_interval;

    typedef struct {
        lsra_pkg::t_outcome outcome;
        logic [3:0]  reg_index;
        logic [15:0] spilled_id;
        logic [17:0] spill_offset;
        logic [3:0]  expired_count;
    } t_alloc;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] start_point;
    logic [15:0] end_point;
    logic [15:0] value_id;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  outcome;
    logic [3:0]  reg_index;
    logic [15:0] spilled_id;
    logic [17:0] spill_offset;
    logic [3:0]  expired_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    t_interval   pending_intervals[$];
    t_alloc      expected_allocs[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          idle_cycles;
    logic        stimulus_done;

    // Allocator state mirror.
    int          reg_count;
    int          act_n;
    logic [15:0] act_end[lsra_pkg::POOL_REGS];
    logic [15:0] act_id[lsra_pkg::POOL_REGS];
    logic [3:0]  act_reg[lsra_pkg::POOL_REGS];
    logic [3:0]  free_regs[$];
    logic [17:0] stack_offset;

    linear_scan_register_allocator_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_start_point  (start_point),
        .i_end_point    (end_point),
        .i_value_id     (value_id),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_outcome      (outcome),
        .o_reg_index    (reg_index),
        .o_spilled_id   (spilled_id),
        .o_spill_offset (spill_offset),
        .o_expired_count(expired_count),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void reset_allocator(int count);
        reg_count = (count > lsra_pkg::POOL_REGS) ? lsra_pkg::POOL_REGS : count;
        act_n = 0;
        free_regs.delete();
        for (int i = 0; i < reg_count; i++) begin
            free_regs.insert(free_regs.size(), 4'(i));
        end
        stack_offset = '0;
    endfunction

    function automatic logic [17:0] claim_slot();
        logic [17:0] off;
        off = stack_offset;
        if (stack_offset <= lsra_pkg::OFFSET_MAX - lsra_pkg::SLOT_BYTES) begin
            stack_offset = stack_offset + lsra_pkg::SLOT_BYTES;
        end else begin
            stack_offset = lsra_pkg::OFFSET_MAX;
        end
        return off;
    endfunction

    function automatic void drop_active(int pos);
        for (int i = pos; i < act_n - 1; i++) begin
            act_end[i] = act_end[i + 1];
            act_id[i]  = act_id[i + 1];
            act_reg[i] = act_reg[i + 1];
        end
        act_n--;
    endfunction

    function automatic t_alloc allocate(t_interval iv);
        t_alloc r;
        logic   gone[lsra_pkg::POOL_REGS];
        logic   back[lsra_pkg::POOL_REGS];
        int     nexp;
        int     best;
        int     last;
        r = '{lsra_pkg::OUT_FREE, 4'd0, 16'd0, 18'd0, 4'd0};
        nexp = 0;
        for (int i = 0; i < lsra_pkg::POOL_REGS; i++) begin
            gone[i] = (i < act_n) && (act_end[i] < iv.start_point);
            back[i] = 1'b0;
            if (gone[i]) nexp++;
        end
        for (int k = 0; k < nexp; k++) begin
            best = -1;
            for (int i = 0; i < act_n; i++) begin
                if (gone[i] && !back[i] && (best < 0 || act_id[i] < act_id[best])) best = i;
            end
            back[best] = 1'b1;
            if (free_regs.size() < lsra_pkg::POOL_REGS) begin
                free_regs.insert(free_regs.size(), act_reg[best]);
            end
        end
        for (int i = act_n - 1; i >= 0; i--) begin
            if (gone[i]) drop_active(i);
        end
        r.expired_count = 4'(nexp);
        if (act_n < reg_count && free_regs.size() > 0) begin
            r.reg_index = free_regs[0];
            free_regs.delete(0);
            act_end[act_n] = iv.end_point;
            act_id[act_n]  = iv.value_id;
            act_reg[act_n] = r.reg_index;
            act_n++;
        end else begin
            last = -1;
            for (int i = 0; i < act_n; i++) begin
                if (last < 0 || act_end[i] >= act_end[last]) last = i;
            end
            if (last >= 0 && act_end[last] > iv.end_point) begin
                r.outcome      = lsra_pkg::OUT_STEAL;
                r.reg_index    = act_reg[last];
                r.spilled_id   = act_id[last];
                r.spill_offset = claim_slot();
                drop_active(last);
                act_end[act_n] = iv.end_point;
                act_id[act_n]  = iv.value_id;
                act_reg[act_n] = r.reg_index;
                act_n++;
            end else begin
                r.outcome      = lsra_pkg::OUT_SPILL;
                r.spilled_id   = iv.value_id;
                r.spill_offset = claim_slot();
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Driver.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pending_intervals.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_interval iv;
                iv = pending_intervals[0];
                pending_intervals.delete(0);
                expected_allocs.insert(expected_allocs.size(), allocate(iv));
                in_valid    <= 1'b1;
                start_point <= iv.start_point;
                end_point   <= iv.end_point;
                value_id    <= iv.value_id;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_allocs.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    t_alloc w;
                    w = expected_allocs[0];
                    expected_allocs.delete(0);
                    if (outcome != w.outcome) report_mismatch("outcome", outcome, w.outcome);
                    if (reg_index != w.reg_index)
                        report_mismatch("reg_index", reg_index, w.reg_index);
                    if (spilled_id != w.spilled_id)
                        report_mismatch("spilled_id", spilled_id, w.spilled_id);
                    if (spill_offset != w.spill_offset)
                        report_mismatch("spill_offset", spill_offset, w.spill_offset);
                    if (expired_count != w.expired_count)
                        report_mismatch("expired_count", expired_count, w.expired_count);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready) || stimulus_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_intervals.size() > 0 || expected_allocs.size() > 0 || in_valid) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg_count(logic [3:0] count);
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        reset_allocator(count);
        @(posedge clk);
    endtask

    function automatic void add_interval(logic [15:0] s, logic [15:0] e, logic [15:0] id);
        pending_intervals.insert(pending_intervals.size(), '{s, e, id});
    endfunction

    // Mostly well-formed intervals with mostly ascending starts, mostly short and clustered
    // so that expiry, stealing and spilling all happen often.
    task automatic queue_random(int n);
        logic [15:0] s;
        int          span;
        s = 16'($urandom_range(200));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                add_interval(16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                if ($urandom_range(9) == 0) s = 16'($urandom);
                else if (s < 16'hFFF0) s = s + 16'($urandom_range(3));
                span = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(24);
                add_interval(s, (s + span > 65535) ? 16'hFFFF : 16'(s + span),
                             ($urandom_range(3) == 0) ? 16'($urandom_range(7))
                                                      : 16'($urandom));
            end
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        start_point   = '0;
        end_point     = '0;
        value_id      = '0;
        error_count   = 0;
        idle_cycles   = 0;
        stimulus_done = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 64;
        reset_allocator(9);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, steals, equal ends, expiry by id order.
        add_interval(16'd0, 16'd0, 16'd0);
        add_interval(16'd0, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 7; i++) add_interval(16'd1, 16'd50, 16'(100 - i));
        add_interval(16'd1, 16'd10, 16'h5555);
        add_interval(16'd2, 16'd50, 16'hAAAA);
        add_interval(16'd2, 16'd50, 16'd7);
        add_interval(16'd60, 16'd70, 16'd3);
        add_interval(16'd5, 16'd5, 16'd3);
        add_interval(16'hFFFF, 16'hFFFF, 16'd1);
        add_interval(16'hFFFF, 16'h0000, 16'h8000);
        wait_drained();

        write_reg_count(4'd1);
        add_interval(16'd0, 16'd20, 16'd1);
        add_interval(16'd1, 16'd10, 16'd2);
        add_interval(16'd2, 16'd30, 16'd3);
        add_interval(16'd40, 16'd41, 16'd4);
        wait_drained();

        write_reg_count(4'd0);
        add_interval(16'd0, 16'd1, 16'd9);
        add_interval(16'd3, 16'd4, 16'd10);
        wait_drained();

        write_reg_count(4'd15);
        add_interval(16'd0, 16'd1, 16'd9);
        wait_drained();

        write_reg_count(4'd3);
        queue_random(400);
        wait_drained();

        send_idle_pct = 64;
        recv_idle_pct = 33;
        write_reg_count(4'd9);
        queue_random(400);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg_count(4'd2);
        queue_random(300);
        wait_drained();

        write_reg_count(4'd5);
        queue_random(400);
        wait_drained();

        stimulus_done = 1'b1;
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
